>>> rtl/core/rlce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlce_pkg
// Shared constants and types for the ring list cursor engine.
// ----------------------------------------------------------------------------
package rlce_pkg;

   localparam int CAPACITY_DEF = 16;

   localparam int REQ_TYPE_W = 4;
   localparam int DATA_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 4;
   localparam int OCC_W      = 5;

   localparam logic [REQ_TYPE_W-1:0] OP_INS_AFTER  = 4'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_INS_BEFORE = 4'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_INS_ADV    = 4'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_REMOVE     = 4'd3;
   localparam logic [REQ_TYPE_W-1:0] OP_NEXT       = 4'd4;
   localparam logic [REQ_TYPE_W-1:0] OP_PREV       = 4'd5;
   localparam logic [REQ_TYPE_W-1:0] OP_CLEAR      = 4'd6;
   localparam logic [REQ_TYPE_W-1:0] OP_SEARCH     = 4'd7;
   localparam logic [REQ_TYPE_W-1:0] OP_READ_ALL   = 4'd8;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_END   = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_LINK,
      S_WALK,
      S_END
   } state_type;

endpackage
`default_nettype wire

>>> rtl/core/rlce_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlce_req_if
// Request channel: valid/ready handshake with request code and value.
// ----------------------------------------------------------------------------
interface rlce_req_if;
   logic                                valid;
   logic                                ready;
   logic [rlce_pkg::REQ_TYPE_W-1:0]     req_type;
   logic signed [rlce_pkg::DATA_W-1:0]  value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rlce_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlce_rsp_if
// Response channel: valid/ready handshake with status, data and position.
// ----------------------------------------------------------------------------
interface rlce_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rlce_pkg::STATUS_W-1:0]       status;
   logic signed [rlce_pkg::DATA_W-1:0]  data;
   logic [rlce_pkg::POS_W-1:0]          position;
   logic [rlce_pkg::OCC_W-1:0]          occupancy;
   logic                                last;

   modport source (output valid, output status, output data, output position,
                   output occupancy, output last, input ready);
   modport sink   (input valid, input status, input data, input position,
                   input occupancy, input last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/rlce_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlce_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rlce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   we,
   input  wire logic [AW-1:0]          waddr,
   input  wire logic [WIDTH-1:0]       wdata,
   input  wire logic [AW-1:0]          raddr,
   output logic      [WIDTH-1:0]       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

>>> rtl/core/rlce_free_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rlce_free_stack
// Stack of free node indices. Entries never written since the last clear
// read as their own position, so clear does not rewrite the stack memory.
// ----------------------------------------------------------------------------
module rlce_free_stack #(
   parameter int CAPACITY = rlce_pkg::CAPACITY_DEF,
   localparam int IW = $clog2(CAPACITY)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          clear,
   input  wire logic          pop,
   input  wire logic          push,
   input  wire logic [IW-1:0] push_idx,
   output logic      [IW-1:0] free_idx
);
   localparam int CW = $clog2(CAPACITY + 1);

   logic [CW-1:0]       top_ff, top_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [IW-1:0]       rd_addr, wr_addr;
   logic [IW-1:0]       rd_addr_ff;
   logic                rd_valid_ff;
   logic [IW-1:0]       ram_rdata;

   assign rd_addr = IW'(top_ff - 1'b1);
   assign wr_addr = IW'(top_ff);

   always_comb begin
      top_in   = top_ff;
      valid_in = valid_ff;
      if (clear) begin
         top_in   = CW'(CAPACITY);
         valid_in = '0;
      end else if (pop) begin
         top_in = top_ff - 1'b1;
      end else if (push) begin
         top_in            = top_ff + 1'b1;
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= CW'(CAPACITY);
         valid_ff <= '0;
      end else begin
         top_ff   <= top_in;
         valid_ff <= valid_in;
      end
      rd_addr_ff  <= rd_addr;
      rd_valid_ff <= valid_ff[rd_addr];
   end

   rlce_ram #(
      .WIDTH (IW),
      .DEPTH (CAPACITY)
   ) u_stack_ram (
      .clock (clock),
      .we    (push && !clear),
      .waddr (wr_addr),
      .wdata (push_idx),
      .raddr (rd_addr),
      .rdata (ram_rdata)
   );

   assign free_idx = rd_valid_ff ? ram_rdata : rd_addr_ff;
endmodule
`default_nettype wire

>>> rtl/core/ring_list_cursor_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ring_list_cursor_engine_top
// Circular doubly linked list with a cursor over a fixed node pool.
// ----------------------------------------------------------------------------
// One request at a time. Next, prev, remove, clear, refused inserts and
// inserts into an empty ring respond from the load state; an insert into a
// non-empty ring passes through the link state as well, since its two link
// updates share the single write port of each link memory. Search and read
// all walk the ring along the next links, one node memory read per element,
// and search closes with an end response. A response register lets the
// engine accept the next request while the previous response waits; a
// stalled response channel holds the engine.
// ----------------------------------------------------------------------------
module ring_list_cursor_engine_top #(
   parameter int CAPACITY = rlce_pkg::CAPACITY_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   rlce_req_if.sink     req_bus,
   rlce_rsp_if.source   rsp_bus
);
   localparam int IW     = $clog2(CAPACITY);
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int DW     = rlce_pkg::DATA_W;
   localparam int POS_W  = rlce_pkg::POS_W;
   localparam int OCC_W  = rlce_pkg::OCC_W;
   localparam int ST_W   = rlce_pkg::STATUS_W;
   localparam int OP_W   = rlce_pkg::REQ_TYPE_W;

   rlce_pkg::state_type state_ff, state_in;
   logic [IW-1:0]   cursor_ff, cursor_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [IW-1:0]   c_ff, c_in, n_ff, n_in, nb_ff, nb_in, p_ff, p_in;
   logic [IW-1:0]   i_ff, i_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [DW-1:0]   key_ff, key_in;

   logic            rsp_valid_ff;
   logic [ST_W-1:0] rsp_status_ff;
   logic [DW-1:0]   rsp_data_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic [OCC_W-1:0] rsp_occ_ff;
   logic            rsp_last_ff;

   logic            emit, em_last;
   logic [ST_W-1:0] em_status;
   logic [DW-1:0]   em_data;
   logic [POS_W-1:0] em_pos;

   logic            val_we, nxt_we, prv_we;
   logic [IW-1:0]   val_waddr, nxt_waddr, prv_waddr;
   logic [DW-1:0]   val_wdata;
   logic [IW-1:0]   nxt_wdata, prv_wdata;
   logic [IW-1:0]   node_raddr;
   logic [DW-1:0]   val_rd;
   logic [IW-1:0]   nxt_rd, prv_rd;

   logic            fs_clear, fs_pop, fs_push;
   logic [IW-1:0]   free_idx;

   logic            room, accept, walk_last;

   assign room      = !rsp_valid_ff || rsp_bus.ready;
   assign accept    = req_bus.valid && req_bus.ready;
   assign walk_last = (CW'(i_ff) + 1'b1) == count_ff;
   assign req_bus.ready = (state_ff == rlce_pkg::S_IDLE);

   always_comb begin
      state_in  = state_ff;
      cursor_in = cursor_ff;
      count_in  = count_ff;
      c_in      = c_ff;
      n_in      = n_ff;
      nb_in     = nb_ff;
      p_in      = p_ff;
      i_in      = i_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      emit      = 1'b0;
      em_status = rlce_pkg::ST_OK;
      em_data   = '0;
      em_pos    = '0;
      em_last   = 1'b1;
      val_we    = 1'b0;
      nxt_we    = 1'b0;
      prv_we    = 1'b0;
      val_waddr = free_idx;
      val_wdata = key_ff;
      nxt_waddr = free_idx;
      nxt_wdata = free_idx;
      prv_waddr = free_idx;
      prv_wdata = free_idx;
      fs_clear  = 1'b0;
      fs_pop    = 1'b0;
      fs_push   = 1'b0;
      node_raddr = cursor_ff;

      case (state_ff)
         rlce_pkg::S_IDLE: begin
            if (accept) begin
               op_in    = req_bus.req_type;
               key_in   = req_bus.value;
               state_in = rlce_pkg::S_LOAD;
            end
         end

         rlce_pkg::S_LOAD: begin
            if (room) begin
               state_in = rlce_pkg::S_IDLE;
               emit     = 1'b1;
               c_in     = cursor_ff;
               case (op_ff)
                  rlce_pkg::OP_INS_AFTER, rlce_pkg::OP_INS_BEFORE,
                  rlce_pkg::OP_INS_ADV: begin
                     if (count_ff == CW'(CAPACITY)) begin
                        em_status = rlce_pkg::ST_FULL;
                     end else begin
                        fs_pop   = 1'b1;
                        count_in = count_ff + 1'b1;
                        val_we   = 1'b1;
                        nxt_we   = 1'b1;
                        prv_we   = 1'b1;
                        if (count_ff == '0) begin
                           cursor_in = free_idx;
                        end else begin
                           emit  = 1'b0;
                           n_in  = free_idx;
                           state_in = rlce_pkg::S_LINK;
                           if (op_ff == rlce_pkg::OP_INS_BEFORE) begin
                              nxt_wdata = cursor_ff;
                              prv_wdata = prv_rd;
                              nb_in     = prv_rd;
                           end else begin
                              nxt_wdata = nxt_rd;
                              prv_wdata = cursor_ff;
                              nb_in     = nxt_rd;
                           end
                           if (op_ff == rlce_pkg::OP_INS_ADV) begin
                              cursor_in = free_idx;
                           end
                        end
                     end
                  end
                  rlce_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        em_status = rlce_pkg::ST_EMPTY;
                     end else begin
                        em_data  = val_rd;
                        count_in = count_ff - 1'b1;
                        fs_push  = 1'b1;
                        if (count_ff == CW'(1)) begin
                           cursor_in = '0;
                        end else begin
                           nxt_we    = 1'b1;
                           nxt_waddr = prv_rd;
                           nxt_wdata = nxt_rd;
                           prv_we    = 1'b1;
                           prv_waddr = nxt_rd;
                           prv_wdata = prv_rd;
                           cursor_in = nxt_rd;
                        end
                     end
                  end
                  rlce_pkg::OP_NEXT, rlce_pkg::OP_PREV: begin
                     if (count_ff == '0) begin
                        em_status = rlce_pkg::ST_EMPTY;
                     end else begin
                        cursor_in = (op_ff == rlce_pkg::OP_NEXT) ? nxt_rd : prv_rd;
                     end
                  end
                  rlce_pkg::OP_CLEAR: begin
                     fs_clear  = 1'b1;
                     count_in  = '0;
                     cursor_in = '0;
                  end
                  rlce_pkg::OP_SEARCH, rlce_pkg::OP_READ_ALL: begin
                     if (count_ff == '0) begin
                        em_status = rlce_pkg::ST_EMPTY;
                     end else begin
                        emit     = 1'b0;
                        p_in     = cursor_ff;
                        i_in     = '0;
                        state_in = rlce_pkg::S_WALK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         rlce_pkg::S_LINK: begin
            if (room) begin
               emit     = 1'b1;
               state_in = rlce_pkg::S_IDLE;
               nxt_we   = 1'b1;
               prv_we   = 1'b1;
               if (op_ff == rlce_pkg::OP_INS_BEFORE) begin
                  nxt_waddr = nb_ff;
                  nxt_wdata = n_ff;
                  prv_waddr = c_ff;
                  prv_wdata = n_ff;
               end else begin
                  prv_waddr = nb_ff;
                  prv_wdata = n_ff;
                  nxt_waddr = c_ff;
                  nxt_wdata = n_ff;
               end
            end
         end

         rlce_pkg::S_WALK: begin
            node_raddr = p_ff;
            if (room) begin
               node_raddr = nxt_rd;
               p_in       = nxt_rd;
               i_in       = i_ff + 1'b1;
               em_pos     = POS_W'(i_ff);
               em_data    = val_rd;
               if (op_ff == rlce_pkg::OP_READ_ALL) begin
                  emit    = 1'b1;
                  em_last = walk_last;
                  if (walk_last) begin
                     state_in = rlce_pkg::S_IDLE;
                  end
               end else begin
                  emit    = (val_rd == key_ff);
                  em_last = 1'b0;
                  if (walk_last) begin
                     state_in = rlce_pkg::S_END;
                  end
               end
            end
         end

         rlce_pkg::S_END: begin
            if (room) begin
               emit      = 1'b1;
               em_status = rlce_pkg::ST_END;
               state_in  = rlce_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = rlce_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlce_pkg::S_IDLE;
         cursor_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         count_ff  <= count_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      c_ff   <= c_in;
      n_ff   <= n_in;
      nb_ff  <= nb_in;
      p_ff   <= p_in;
      i_ff   <= i_in;
      op_ff  <= op_in;
      key_ff <= key_in;
      if (emit) begin
         rsp_status_ff <= em_status;
         rsp_data_ff   <= em_data;
         rsp_pos_ff    <= em_pos;
         rsp_occ_ff    <= OCC_W'(count_in);
         rsp_last_ff   <= em_last;
      end
   end

   rlce_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_value_ram (
      .clock (clock),
      .we    (val_we),
      .waddr (val_waddr),
      .wdata (val_wdata),
      .raddr (node_raddr),
      .rdata (val_rd)
   );

   rlce_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next_ram (
      .clock (clock),
      .we    (nxt_we),
      .waddr (nxt_waddr),
      .wdata (nxt_wdata),
      .raddr (node_raddr),
      .rdata (nxt_rd)
   );

   rlce_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev_ram (
      .clock (clock),
      .we    (prv_we),
      .waddr (prv_waddr),
      .wdata (prv_wdata),
      .raddr (node_raddr),
      .rdata (prv_rd)
   );

   rlce_free_stack #(.CAPACITY(CAPACITY)) u_free_stack (
      .clock    (clock),
      .reset    (reset),
      .clear    (fs_clear),
      .pop      (fs_pop),
      .push     (fs_push),
      .push_idx (c_in),
      .free_idx (free_idx)
   );

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.status    = rsp_status_ff;
   assign rsp_bus.data      = rsp_data_ff;
   assign rsp_bus.position  = rsp_pos_ff;
   assign rsp_bus.occupancy = rsp_occ_ff;
   assign rsp_bus.last      = rsp_last_ff;
endmodule
`default_nettype wire

>>> verif/ring_list_cursor_engine_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ring_list_cursor_engine_top_tb
// Self-checking bench for the ring list cursor engine. A directed table covers
// the empty pool, value extremes, every request code and unused codes; a full
// pool with overflows and random bursts of list traffic follow. Every response
// is checked field by field against a behavioral ring model, under random
// source gaps, sink stalls and one long sink hold-off that backs up requests.
// ----------------------------------------------------------------------------
module ring_list_cursor_engine_top_tb;

   localparam int CAP        = rlce_pkg::CAPACITY_DEF;
   localparam int STATUS_W   = rlce_pkg::STATUS_W;
   localparam int DATA_W     = rlce_pkg::DATA_W;
   localparam int POS_W      = rlce_pkg::POS_W;
   localparam int OCC_W      = rlce_pkg::OCC_W;
   localparam int REQ_TYPE_W = rlce_pkg::REQ_TYPE_W;
   localparam int N_RANDOM   = 112;
   localparam int MAX_CYCLES = 400000;

   // unused request codes
   localparam logic [REQ_TYPE_W-1:0] OP_RSVD_LO = 4'd9;
   localparam logic [REQ_TYPE_W-1:0] OP_RSVD_HI = 4'd15;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic signed [DATA_W-1:0]  data;
      logic [POS_W-1:0]          position;
      logic [OCC_W-1:0]          occupancy;
      logic                      last;
   } rsp_type;

   typedef struct {
      logic [REQ_TYPE_W-1:0]     op;
      logic signed [DATA_W-1:0]  value;
      bit                        has_rsp;
      logic [STATUS_W-1:0]       status;
      logic signed [DATA_W-1:0]  data;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rlce_req_if req_bus ();
   rlce_rsp_if rsp_bus ();

   ring_list_cursor_engine_top #(.CAPACITY(CAP)) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ring model
   logic [DATA_W-1:0] ring_val  [CAP];
   logic [3:0]        ring_next [CAP];
   logic [3:0]        ring_prev [CAP];
   logic [3:0]        pool      [CAP];
   int                pool_top;
   logic [3:0]        cur;
   int                count;

   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      cycle_count = 0;
   bit      hold_sink = 1'b0;
   bit      hold_done = 1'b0;
   bit      stim_done = 1'b0;

   function automatic rsp_type mk_rsp(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] d,
                                      int pos, bit lst);
      rsp_type r;
      r.status    = st;
      r.data      = d;
      r.position  = pos[POS_W-1:0];
      r.occupancy = count[OCC_W-1:0];
      r.last      = lst;
      return r;
   endfunction

   function automatic void ring_clear();
      for (int i = 0; i < CAP; i++) pool[i] = i[3:0];
      pool_top = CAP;
      count    = 0;
      cur      = '0;
   endfunction

   function automatic void ring_apply(logic [REQ_TYPE_W-1:0] op, logic [DATA_W-1:0] v);
      logic [3:0] n, nb, pv, p;
      logic [DATA_W-1:0] d;
      case (op)
         rlce_pkg::OP_INS_AFTER, rlce_pkg::OP_INS_BEFORE, rlce_pkg::OP_INS_ADV: begin
            if (pool_top == 0 || count >= CAP) begin
               expected_rsps.push_back(mk_rsp(rlce_pkg::ST_FULL, '0, 0, 1'b1));
               return;
            end
            pool_top--;
            n = pool[pool_top];
            ring_val[n] = v;
            if (count == 0) begin
               ring_next[n] = n;
               ring_prev[n] = n;
               cur = n;
            end else if (op != rlce_pkg::OP_INS_BEFORE) begin
               nb = ring_next[cur];
               ring_next[n] = nb;
               ring_prev[n] = cur;
               ring_prev[nb] = n;
               ring_next[cur] = n;
            end else begin
               nb = ring_prev[cur];
               ring_next[n] = cur;
               ring_prev[n] = nb;
               ring_next[nb] = n;
               ring_prev[cur] = n;
            end
            count++;
            if (op == rlce_pkg::OP_INS_ADV) cur = ring_next[cur];
            expected_rsps.push_back(mk_rsp(rlce_pkg::ST_OK, '0, 0, 1'b1));
         end
         rlce_pkg::OP_REMOVE: begin
            if (count == 0) begin
               expected_rsps.push_back(mk_rsp(rlce_pkg::ST_EMPTY, '0, 0, 1'b1));
               return;
            end
            d = ring_val[cur];
            n = cur;
            if (count == 1) cur = '0;
            else begin
               nb = ring_next[n];
               pv = ring_prev[n];
               ring_next[pv] = nb;
               ring_prev[nb] = pv;
               cur = nb;
            end
            count--;
            if (pool_top < CAP) begin
               pool[pool_top] = n;
               pool_top++;
            end
            expected_rsps.push_back(mk_rsp(rlce_pkg::ST_OK, d, 0, 1'b1));
         end
         rlce_pkg::OP_NEXT, rlce_pkg::OP_PREV: begin
            if (count == 0) begin
               expected_rsps.push_back(mk_rsp(rlce_pkg::ST_EMPTY, '0, 0, 1'b1));
               return;
            end
            cur = (op == rlce_pkg::OP_NEXT) ? ring_next[cur] : ring_prev[cur];
            expected_rsps.push_back(mk_rsp(rlce_pkg::ST_OK, '0, 0, 1'b1));
         end
         rlce_pkg::OP_CLEAR: begin
            ring_clear();
            expected_rsps.push_back(mk_rsp(rlce_pkg::ST_OK, '0, 0, 1'b1));
         end
         rlce_pkg::OP_SEARCH, rlce_pkg::OP_READ_ALL: begin
            if (count == 0) begin
               expected_rsps.push_back(mk_rsp(rlce_pkg::ST_EMPTY, '0, 0, 1'b1));
               return;
            end
            p = cur;
            for (int i = 0; i < count; i++) begin
               if (op == rlce_pkg::OP_READ_ALL)
                  expected_rsps.push_back(mk_rsp(rlce_pkg::ST_OK, ring_val[p], i,
                                                 i + 1 == count));
               else if (ring_val[p] == v)
                  expected_rsps.push_back(mk_rsp(rlce_pkg::ST_OK, v, i, 1'b0));
               p = ring_next[p];
            end
            if (op == rlce_pkg::OP_SEARCH)
               expected_rsps.push_back(mk_rsp(rlce_pkg::ST_END, '0, 0, 1'b1));
         end
         default: expected_rsps.push_back(mk_rsp(rlce_pkg::ST_OK, '0, 0, 1'b1));
      endcase
   endfunction

   // request driver
   task automatic send_req(logic [REQ_TYPE_W-1:0] op, logic [DATA_W-1:0] v);
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= op;
      req_bus.value    <= v;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      ring_apply(op, v);
   endtask

   task automatic source_gap();
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] rand_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return $urandom();
         default: return $urandom_range(0, 7);
      endcase
   endfunction

   function automatic logic [REQ_TYPE_W-1:0] rand_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) begin
         if (r[1:0] == 2'd3) return rlce_pkg::OP_INS_ADV;
         return r[0] ? rlce_pkg::OP_INS_BEFORE : rlce_pkg::OP_INS_AFTER;
      end
      if (r < 58) return rlce_pkg::OP_REMOVE;
      if (r < 66) return rlce_pkg::OP_NEXT;
      if (r < 74) return rlce_pkg::OP_PREV;
      if (r < 85) return rlce_pkg::OP_SEARCH;
      if (r < 94) return rlce_pkg::OP_READ_ALL;
      if (r < 97) return rlce_pkg::OP_CLEAR;
      return REQ_TYPE_W'($urandom_range(int'(OP_RSVD_LO), int'(OP_RSVD_HI)));
   endfunction

   dir_row_type dir_table[] = '{
      '{rlce_pkg::OP_REMOVE,     32'sd0,        1'b1, rlce_pkg::ST_EMPTY, 32'sd0},
      '{rlce_pkg::OP_NEXT,       32'sd0,        1'b1, rlce_pkg::ST_EMPTY, 32'sd0},
      '{rlce_pkg::OP_PREV,       32'sd0,        1'b1, rlce_pkg::ST_EMPTY, 32'sd0},
      '{rlce_pkg::OP_SEARCH,     32'sd5,        1'b1, rlce_pkg::ST_EMPTY, 32'sd0},
      '{rlce_pkg::OP_READ_ALL,   32'sd0,        1'b1, rlce_pkg::ST_EMPTY, 32'sd0},
      '{rlce_pkg::OP_CLEAR,      32'sd0,        1'b1, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_INS_AFTER,  32'h8000_0000, 1'b1, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_REMOVE,     32'sd0,        1'b1, rlce_pkg::ST_OK,    32'h8000_0000},
      '{rlce_pkg::OP_INS_ADV,    32'h7FFF_FFFF, 1'b1, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_INS_BEFORE, 32'hFFFF_FFFF, 1'b0, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_INS_AFTER,  32'h7FFF_FFFF, 1'b0, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_INS_ADV,    32'h5555_AAAA, 1'b0, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_NEXT,       32'sd0,        1'b0, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_PREV,       32'sd0,        1'b0, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_SEARCH,     32'h7FFF_FFFF, 1'b0, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_SEARCH,     32'sd1,        1'b0, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_READ_ALL,   32'sd0,        1'b0, rlce_pkg::ST_OK,    32'sd0},
      '{OP_RSVD_LO,              32'sd0,        1'b1, rlce_pkg::ST_OK,    32'sd0},
      '{OP_RSVD_HI,              32'hFFFF_FFFF, 1'b1, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_REMOVE,     32'sd0,        1'b0, rlce_pkg::ST_OK,    32'sd0},
      '{rlce_pkg::OP_CLEAR,      32'sd0,        1'b1, rlce_pkg::ST_OK,    32'sd0}
   };

   initial begin
      int n_sent;
      rsp_type typed;
      req_bus.valid    <= 1'b0;
      req_bus.req_type <= '0;
      req_bus.value    <= '0;
      ring_clear();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) begin
         send_req(dir_table[i].op, dir_table[i].value);
         if (dir_table[i].has_rsp) begin
            // typed-in status and data replace the model's
            typed = expected_rsps[$];
            typed.status = dir_table[i].status;
            typed.data   = dir_table[i].data;
            expected_rsps[$] = typed;
         end
         if ($urandom_range(0, 2) == 0) source_gap();
      end

      // fill the pool to the brim, then overflow each insert kind
      for (int i = 0; i < CAP; i++)
         send_req(rlce_pkg::OP_INS_AFTER, i[0] ? 32'sd3 : rand_value());
      send_req(rlce_pkg::OP_INS_AFTER, 32'sd1);
      send_req(rlce_pkg::OP_INS_BEFORE, 32'sd1);
      send_req(rlce_pkg::OP_INS_ADV, 32'sd1);
      send_req(rlce_pkg::OP_SEARCH, 32'sd3);
      // long sink hold-off while requests keep coming
      hold_sink = 1'b1;
      for (int i = 0; i < 6; i++) send_req(rlce_pkg::OP_READ_ALL, '0);
      send_req(rlce_pkg::OP_CLEAR, '0);

      n_sent = 0;
      while (n_sent < N_RANDOM) begin
         for (int b = $urandom_range(1, 12); b > 0 && n_sent < N_RANDOM; b--) begin
            send_req(rand_op(), rand_value());
            n_sent++;
         end
         if ($urandom_range(0, 3) != 0) source_gap();
      end
      req_bus.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // sink: random stall pattern plus one long hold-off
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_sink && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_done = 1'b1;
         end
         if (cycle_count % 256 < 64) rsp_bus.ready <= 1'b1;
         else rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // response checker
   always @(posedge clock) begin
      rsp_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.status, rsp_bus.data, rsp_bus.position,
                 rsp_bus.occupancy, rsp_bus.last};
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: %p", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      while (expected_rsps.size() != 0 && cycle_count < MAX_CYCLES) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && cycle_count < MAX_CYCLES && expected_rsps.size() == 0) begin
         $display("[ring_list_cursor_engine_top] OK");
      end else begin
         $display("[ring_list_cursor_engine_top] ERROR");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= MAX_CYCLES + 100);
      $display("[ring_list_cursor_engine_top] ERROR");
      $finish;
   end

endmodule
`default_nettype wire

>>> filelist.f
rtl/core/rlce_pkg.sv
rtl/core/rlce_req_if.sv
rtl/core/rlce_rsp_if.sv
rtl/core/rlce_ram.sv
rtl/core/rlce_free_stack.sv
rtl/core/ring_list_cursor_engine_top.sv
verif/ring_list_cursor_engine_top_tb.sv
